// File: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define WH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/wh_pkg.sv
`default_nettype none
package wh_pkg;

    localparam logic [31:0] INIT_A = 32'h243F6A88;
    localparam logic [31:0] INIT_B = 32'h85A308D3;
    localparam logic [31:0] INIT_C = 32'h13198A2E;
    localparam logic [31:0] INIT_D = 32'h03707344;

    localparam logic [31:0] MIX_B = 32'hA5A5A5A5;
    localparam logic [31:0] MIX_D = 32'h5A5A5A5A;
    localparam logic [31:0] FF_A  = 32'hDEADBEEF;
    localparam logic [31:0] FF_B  = 32'h0F0F0F0F;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] RK [16] = '{
        32'h9E3779B9, 32'h7F4A7C15, 32'hC6EF3720, 32'h165667B1,
        32'h85EBCA6B, 32'h27D4EB2F, 32'hB7E15163, 32'h9DDFEA76,
        32'hE08C1D64, 32'h4F1BBCDC, 32'hA3B19535, 32'h6C62272E,
        32'hFBF44E5F, 32'h1C6EF372, 32'hE12B4F97, 32'hC6D3A7E4
    };

    typedef logic [4:0] t_amt;

    // round index modulo m, plus one
    localparam t_amt AMT_M5 [16] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd1, 5'd2, 5'd3,
        5'd4, 5'd5, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd1
    };
    localparam t_amt AMT_M7 [16] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd1,
        5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd1, 5'd2
    };
    localparam t_amt AMT_M11 [16] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
        5'd9, 5'd10, 5'd11, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5
    };
    localparam t_amt AMT_M13 [16] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
        5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd1, 5'd2, 5'd3
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
    } t_out;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_chain;

    typedef enum logic [1:0] {
        OP_ABSORB,
        OP_FEED,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        WS_DATA,
        WS_PAD,
        WS_LEN_LO,
        WS_LEN_HI
    } t_wsel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FEED,
        ST_FINISH,
        ST_DONE
    } t_state;

    function automatic logic [31:0] f_rol(input logic [31:0] v, input t_amt n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] f_ch(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
        return (x & y) | (~x & z);
    endfunction

    function automatic logic [31:0] f_maj(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
        return (x & y) | (x & z) | (y & z);
    endfunction

    function automatic logic [31:0] f_par(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
        return x ^ y ^ z;
    endfunction

endpackage
`default_nettype wire

// File: sv/wh_round.sv
`default_nettype none
module wh_round import wh_pkg::*; (
    input  t_op         i_op,
    input  logic [3:0]  i_round,
    input  logic [2:0]  i_sub,
    input  logic [31:0] i_word,
    input  t_chain      i_chain,
    output t_chain      o_chain
);

    logic [31:0] a, b, c, d, w;
    logic [31:0] ta, tb, tc, td;
    logic [3:0]  k3, k6, k9, k4, k8, k2;
    t_amt        rp1;
    t_chain      abs_out, ff_out, fin_out;

    always_comb begin
        a   = i_chain.a;
        b   = i_chain.b;
        c   = i_chain.c;
        d   = i_chain.d;
        w   = i_word;
        k3  = i_round + 4'd3;
        k6  = i_round + 4'd6;
        k9  = i_round + 4'd9;
        k4  = i_round + 4'd4;
        k8  = i_round + 4'd8;
        k2  = i_round + 4'd2;
        rp1 = {1'b0, i_round} + 5'd1;

        ta = f_rol(a + f_ch(b, c, d) + w + RK[i_round], AMT_M13[i_round]);
        tb = f_rol(b + f_maj(c, d, a) + w + RK[k3], rp1) + MIX_B;
        tc = f_rol(c + f_par(d, a, b) + w + RK[k6], rp1) ^ ta;
        td = f_rol(d + f_ch(a, b, c) + w + RK[k9], rp1) + MIX_D;
        abs_out.a = ta ^ (tb >> AMT_M5[i_round]);
        abs_out.b = tb ^ (tc << AMT_M7[i_round]);
        abs_out.c = tc ^ (td >> AMT_M11[i_round]);
        abs_out.d = td ^ (ta << AMT_M13[i_round]);

        ff_out.a = a ^ (w + FF_A);
        ff_out.b = b + (w ^ FF_B);
        ff_out.c = c ^ f_rol(w, 5'd17);
        ff_out.d = d + f_rol(w, 5'd3);

        fin_out = i_chain;
        case (i_sub)
            3'd0: fin_out.a = a ^ f_rol(f_ch(b, c, d) + RK[i_round], AMT_M7[i_round]);
            3'd1: fin_out.b = b ^ f_rol(f_maj(c, d, a) + RK[k4], AMT_M11[i_round]);
            3'd2: fin_out.c = c ^ f_rol(f_par(d, a, b) + RK[k8], AMT_M13[i_round]);
            3'd3: fin_out.d = d ^ f_rol(f_ch(a, b, c) + RK[k2], rp1);
            3'd4: fin_out.a = a + (b ^ c);
            3'd5: fin_out.b = b + (c ^ d);
            3'd6: fin_out.c = c + (d ^ a);
            3'd7: fin_out.d = d + (a ^ b);
            default: fin_out = i_chain;
        endcase

        case (i_op)
            OP_ABSORB: o_chain = abs_out;
            OP_FEED:   o_chain = ff_out;
            OP_FINISH: o_chain = fin_out;
            default:   o_chain = i_chain;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/word_hash_128.sv
// An item that does not complete a word is taken without a stall; one that completes a
// word holds the input for 16 rounds and a feed-forward on the shared round unit.
// A last item holds the input for three word absorbs (four if it also completes a word),
// 128 finalization steps (one lane operation per cycle) and a digest load.
// The block takes no new item while it is busy; the single round unit sets how fast bytes go.
// Reset: synchronous, active low; chain words return to their initial constants, counters clear.
`default_nettype none
module word_hash_128 import wh_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state      r_state, n_state;
    t_chain      r_chain, n_chain;
    logic [23:0] r_pend, n_pend;
    logic [1:0]  r_cnt, n_cnt;
    logic [63:0] r_bits, n_bits;
    logic [31:0] r_word, n_word;
    t_wsel       r_wsel, n_wsel;
    logic        r_fin, n_fin;
    logic [3:0]  r_round, n_round;
    logic [2:0]  r_sub, n_sub;
    t_out        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_op         op;
    t_chain      round_out;
    logic        acc;
    logic        word_full;
    logic        out_free;

    function automatic logic [31:0] pad_word(input logic [23:0] p, input logic [1:0] c);
        return {8'h00, p} | ({24'h0, PAD_BYTE} << {c, 3'b000});
    endfunction

    assign acc       = i_in_valid && !o_in_stall;
    assign word_full = i_in_data.has_byte && (r_cnt == 2'd3);
    assign out_free  = !r_out_valid || !i_out_stall;

    wh_round u_round (
        .i_op    (op),
        .i_round (r_round),
        .i_sub   (r_sub),
        .i_word  (r_word),
        .i_chain (r_chain),
        .o_chain (round_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && (word_full || i_in_data.last)) begin
                    n_state = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                if (r_round == 4'd15) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                if (r_wsel == WS_DATA && !r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_wsel == WS_LEN_HI) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_ABSORB;
                end
            end
            ST_FINISH: begin
                if (r_round == 4'd15 && r_sub == 3'd7) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_chain     = r_chain;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_bits      = r_bits;
        n_word      = r_word;
        n_wsel      = r_wsel;
        n_fin       = r_fin;
        n_round     = r_round;
        n_sub       = r_sub;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_stall  = (r_state != ST_IDLE);
        op          = OP_FINISH;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_fin   = i_in_data.last;
                    n_round = 4'd0;
                    n_sub   = 3'd0;
                    if (i_in_data.has_byte) begin
                        n_bits = r_bits + 64'd8;
                        if (r_cnt == 2'd3) begin
                            n_pend = 24'h0;
                            n_cnt  = 2'd0;
                        end else begin
                            n_pend = r_pend | ({16'h0, i_in_data.data_byte} << {r_cnt, 3'b000});
                            n_cnt  = r_cnt + 2'd1;
                        end
                    end
                    if (word_full) begin
                        n_word = {i_in_data.data_byte, r_pend};
                        n_wsel = WS_DATA;
                    end else begin
                        n_word = pad_word(n_pend, n_cnt);
                        n_wsel = WS_PAD;
                    end
                end
            end
            ST_ABSORB: begin
                op      = OP_ABSORB;
                n_chain = round_out;
                n_round = r_round + 4'd1;
            end
            ST_FEED: begin
                op      = OP_FEED;
                n_chain = round_out;
                n_round = 4'd0;
                n_sub   = 3'd0;
                case (r_wsel)
                    WS_DATA: begin
                        n_wsel = WS_PAD;
                        n_word = pad_word(r_pend, r_cnt);
                    end
                    WS_PAD: begin
                        n_wsel = WS_LEN_LO;
                        n_word = r_bits[31:0];
                    end
                    WS_LEN_LO: begin
                        n_wsel = WS_LEN_HI;
                        n_word = r_bits[63:32];
                    end
                    default: n_wsel = r_wsel;
                endcase
            end
            ST_FINISH: begin
                op      = OP_FINISH;
                n_chain = round_out;
                n_sub   = r_sub + 3'd1;
                if (r_sub == 3'd7) begin
                    n_round = r_round + 4'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out.digest_a = r_chain.a;
                    n_out.digest_b = r_chain.b;
                    n_out.digest_c = r_chain.c;
                    n_out.digest_d = r_chain.d;
                    n_out_valid    = 1'b1;
                    n_chain        = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
                    n_pend         = 24'h0;
                    n_cnt          = 2'd0;
                    n_bits         = 64'h0;
                    n_fin          = 1'b0;
                end
            end
            default: begin
                op = OP_FINISH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
            r_pend      <= 24'h0;
            r_cnt       <= 2'd0;
            r_bits      <= 64'h0;
            r_wsel      <= WS_DATA;
            r_fin       <= 1'b0;
            r_round     <= 4'd0;
            r_sub       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_bits      <= n_bits;
            r_wsel      <= n_wsel;
            r_fin       <= n_fin;
            r_round     <= n_round;
            r_sub       <= n_sub;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: sv/wh_chk.sv
`default_nettype none
`include "assert_macros.svh"
module wh_chk import wh_pkg::*; (
    input wire  i_clk,
    input wire  i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic acc;

    assign acc = i_in_valid && !o_in_stall;

    `WH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `WH_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, acc && i_in_data.last, o_in_stall)
    `WH_ASSERT_NEXT(a_empty_idle, i_clk, i_rst_n, acc && !i_in_data.last && !i_in_data.has_byte, !o_in_stall)
    `WH_ASSERT_IMPL(a_out_after_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind word_hash_128 wh_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
    import wh_pkg::*;

    localparam int RAND_ITEMS   = 1400;
    localparam int N_DIRECTED   = 22;
    localparam int SETTLE_LIMIT = 250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_in  in_data = '0;
    t_out out_data;

    bit   quiet = 1'b0;
    int   err_cnt = 0;
    int   n_taken = 0;
    int   n_msgs = 0;
    int   n_bytes = 0;
    int   n_ignored = 0;
    int   n_digests = 0;
    int   longest_msg = 0;

    logic [31:0] ch_a, ch_b, ch_c, ch_d;
    logic [23:0] pend_bytes;
    logic [1:0]  pend_cnt;
    logic [63:0] msg_bits;
    t_out        digests_due [$];
    t_in         dir_items [0:N_DIRECTED-1];

    word_hash_128 i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] round_const(input int idx);
        case (idx & 15)
            0:  return 32'h9E3779B9;
            1:  return 32'h7F4A7C15;
            2:  return 32'hC6EF3720;
            3:  return 32'h165667B1;
            4:  return 32'h85EBCA6B;
            5:  return 32'h27D4EB2F;
            6:  return 32'hB7E15163;
            7:  return 32'h9DDFEA76;
            8:  return 32'hE08C1D64;
            9:  return 32'h4F1BBCDC;
            10: return 32'hA3B19535;
            11: return 32'h6C62272E;
            12: return 32'hFBF44E5F;
            13: return 32'h1C6EF372;
            14: return 32'hE12B4F97;
            default: return 32'hC6D3A7E4;
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] pick(input logic [31:0] s, input logic [31:0] t,
                                         input logic [31:0] f);
        return (s & t) | (~s & f);
    endfunction

    function automatic logic [31:0] vote(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
        return (x & y) | (x & z) | (y & z);
    endfunction

    function automatic void hash_reset();
        ch_a = 32'h243F6A88;
        ch_b = 32'h85A308D3;
        ch_c = 32'h13198A2E;
        ch_d = 32'h03707344;
        pend_bytes = '0;
        pend_cnt = '0;
        msg_bits = '0;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        logic [31:0] a, b, c, d, ta, tb, tc, td;
        int r;
        a = ch_a; b = ch_b; c = ch_c; d = ch_d;
        for (r = 0; r < 16; r++) begin
            ta = rotl(a + pick(b, c, d) + w + round_const(r), (r % 13) + 1);
            tb = rotl(b + vote(c, d, a) + w + round_const(r + 3), (r % 17) + 1)
                 + 32'hA5A5A5A5;
            tc = rotl(c + (d ^ a ^ b) + w + round_const(r + 6), (r % 19) + 1) ^ ta;
            td = rotl(d + pick(a, b, c) + w + round_const(r + 9), (r % 23) + 1)
                 + 32'h5A5A5A5A;
            a = ta ^ (tb >> ((r % 5) + 1));
            b = tb ^ (tc << ((r % 7) + 1));
            c = tc ^ (td >> ((r % 11) + 1));
            d = td ^ (ta << ((r % 13) + 1));
        end
        ch_a = a ^ (w + 32'hDEADBEEF);
        ch_b = b + (w ^ 32'h0F0F0F0F);
        ch_c = c ^ rotl(w, 17);
        ch_d = d + rotl(w, 3);
    endfunction

    function automatic void finalize_chain();
        logic [31:0] a, b, c, d;
        int r;
        a = ch_a; b = ch_b; c = ch_c; d = ch_d;
        for (r = 0; r < 16; r++) begin
            a = a ^ rotl(pick(b, c, d) + round_const(r), (r % 7) + 1);
            b = b ^ rotl(vote(c, d, a) + round_const(r + 4), (r % 11) + 1);
            c = c ^ rotl((d ^ a ^ b) + round_const(r + 8), (r % 13) + 1);
            d = d ^ rotl(pick(a, b, c) + round_const(r + 2), (r % 17) + 1);
            a = a + (b ^ c);
            b = b + (c ^ d);
            c = c + (d ^ a);
            d = d + (a ^ b);
        end
        ch_a = a; ch_b = b; ch_c = c; ch_d = d;
    endfunction

    function automatic bit hash_item(input t_in it, output t_out dg);
        logic [31:0] pad_word;
        dg = '0;
        if (it.has_byte) begin
            msg_bits = msg_bits + 64'd8;
            if (pend_cnt == 2'd3) begin
                absorb_word({it.data_byte, pend_bytes});
                pend_bytes = '0;
                pend_cnt = '0;
            end else begin
                pend_bytes[8*pend_cnt +: 8] = it.data_byte;
                pend_cnt = pend_cnt + 2'd1;
            end
        end
        if (!it.last)
            return 1'b0;
        pad_word = {8'h00, pend_bytes} | (32'h80 << (8 * pend_cnt));
        absorb_word(pad_word);
        absorb_word(msg_bits[31:0]);
        absorb_word(msg_bits[63:32]);
        finalize_chain();
        dg.digest_a = ch_a;
        dg.digest_b = ch_b;
        dg.digest_c = ch_c;
        dg.digest_d = ch_d;
        hash_reset();
        return 1'b1;
    endfunction

    task automatic send_item(input t_in it);
        t_out dg;
        while (!quiet && $urandom_range(0, 99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (hash_item(it, dg))
            digests_due = {digests_due, dg};
        if (it.has_byte || it.last)
            n_taken++;
        else
            n_ignored++;
        if (it.has_byte)
            n_bytes++;
        if (it.last)
            n_msgs++;
    endtask

    // hold off new input until every digest has been drained
    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digests_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_word(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 8);

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            n_digests++;
            if (digests_due.size() == 0) begin
                $error("digest transaction with no message pending: %h", out_data);
                err_cnt++;
            end else begin
                want = digests_due.pop_front();
                check_word("digest_a", want.digest_a, out_data.digest_a);
                check_word("digest_b", want.digest_b, out_data.digest_b);
                check_word("digest_c", want.digest_c, out_data.digest_c);
                check_word("digest_d", want.digest_d, out_data.digest_d);
            end
        end
    end

    initial begin
        t_in it;
        int  msg_len;
        int  roll;
        int  k;
        bit  close_empty;

        dir_items = '{
            '{8'h00, 1'b0, 1'b1},
            '{8'hA5, 1'b0, 1'b0},
            '{8'hFF, 1'b0, 1'b1},
            '{8'hFF, 1'b1, 1'b1},
            '{8'h00, 1'b1, 1'b1},
            '{8'h01, 1'b1, 1'b0}, '{8'h02, 1'b1, 1'b0}, '{8'h03, 1'b1, 1'b1},
            '{8'h10, 1'b1, 1'b0}, '{8'h20, 1'b1, 1'b0}, '{8'h30, 1'b1, 1'b0},
            '{8'h40, 1'b1, 1'b1},
            '{8'hFF, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0},
            '{8'hFF, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1},
            '{8'h80, 1'b1, 1'b0}, '{8'h7F, 1'b0, 1'b0}, '{8'h55, 1'b1, 1'b0},
            '{8'hAA, 1'b1, 1'b0}, '{8'h01, 1'b1, 1'b1}
        };
        hash_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
            send_item(dir_items[k]);
        drain_pause();
        n_taken = 0;

        while (n_taken < RAND_ITEMS) begin
            quiet = (n_taken >= 500) && (n_taken < 800);
            roll = $urandom_range(0, 99);
            if (roll < 65)
                msg_len = $urandom_range(0, 8);
            else if (roll < 95)
                msg_len = $urandom_range(9, 40);
            else
                msg_len = $urandom_range(41, 130);
            if (msg_len > longest_msg)
                longest_msg = msg_len;
            close_empty = (msg_len == 0) || ($urandom_range(0, 99) < 15);
            for (k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 99) < 5) begin
                    it.data_byte = 8'($urandom_range(0, 255));
                    it.has_byte  = 1'b0;
                    it.last      = 1'b0;
                    send_item(it);
                end
                it.data_byte = 8'($urandom_range(0, 255));
                it.has_byte  = 1'b1;
                it.last      = !close_empty && (k == msg_len - 1);
                send_item(it);
            end
            if (close_empty) begin
                it.data_byte = 8'($urandom_range(0, 255));
                it.has_byte  = 1'b0;
                it.last      = 1'b1;
                send_item(it);
            end
            if ($urandom_range(0, 19) == 0)
                drain_pause();
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (digests_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT) @(posedge clk);

        $display("covered %0d messages (%0d bytes, longest random one %0d bytes)",
                 n_msgs, n_bytes, longest_msg);
        $display("checked %0d digests; %0d idle items skipped, %0d mismatches",
                 n_digests, n_ignored, err_cnt);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
